// ===== rtl/bhd_pkg.sv =====
// Shared types, widths and register indexes of the binomial half downscaler.
package bhd_pkg;

  localparam int unsigned SRC_W             = 32;
  localparam int unsigned PIX_W             = 24;
  localparam int unsigned CH_W              = 8;
  localparam int unsigned NUM_CH            = 3;
  localparam int unsigned SUM_W             = 12;
  localparam int unsigned RND_W             = 13;
  localparam int unsigned CFG_W             = 10;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CNT_W             = 11;
  localparam int unsigned DEF_MAX_SRC_WIDTH = 2048;

  // Rounding term added before the divide by 16.
  localparam logic [RND_W-1:0] ROUND_BIAS = RND_W'(8);

  typedef logic [PIX_W-1:0] pixel_t;

  // One source column of the 3x3 neighborhood.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH  = 2'd0,
    REG_OUT_HEIGHT = 2'd1
  } reg_idx_e;

endpackage

// ===== rtl/bhd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bhd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bhd_filter.sv =====
// 3x3 binomial kernel (1 2 1 / 2 4 2 / 1 2 1) with rounding, per color channel.
module bhd_filter (
  input  bhd_pkg::col_t   left_i,
  input  bhd_pkg::col_t   center_i,
  input  bhd_pkg::col_t   right_i,
  output bhd_pkg::pixel_t pixel_o
);
  import bhd_pkg::*;

  function automatic logic [SUM_W-1:0] ext(input logic [CH_W-1:0] v);
    return {{(SUM_W-CH_W){1'b0}}, v};
  endfunction

  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [RND_W-1:0] rnd;
    pixel_o = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = ext(left_i.top[ch*CH_W +: CH_W])
          + (ext(left_i.mid[ch*CH_W +: CH_W]) << 1)
          + ext(left_i.bot[ch*CH_W +: CH_W])
          + (ext(center_i.top[ch*CH_W +: CH_W]) << 1)
          + (ext(center_i.mid[ch*CH_W +: CH_W]) << 2)
          + (ext(center_i.bot[ch*CH_W +: CH_W]) << 1)
          + ext(right_i.top[ch*CH_W +: CH_W])
          + (ext(right_i.mid[ch*CH_W +: CH_W]) << 1)
          + ext(right_i.bot[ch*CH_W +: CH_W]);
      rnd = {1'b0, sum} + ROUND_BIAS;
      pixel_o[ch*CH_W +: CH_W] = rnd[4 +: CH_W];
    end
  end

endmodule

// ===== rtl/binomial_half_downscaler_unit.sv =====
// Top level of the binomial half downscaler: line stores, column window, handshakes.
//
// Source pixels (XRGB, alpha ignored) enter in raster order on the src channel,
// one transaction per pixel. The frame is 2*out_width+1 pixels wide and
// 2*out_height+1 rows high. For each source pixel at a nonzero even column and row
// one filtered RGB pixel leaves on the out channel, with row_end on the last
// pixel of each output row and frame_end on the last pixel of the frame.
// It is emitted when the lower right pixel of its 3x3 neighborhood arrives.
// A result is registered first in stage 1 and then in the output register.
// Throughput: one source pixel per cycle unless a stalled result holds it; each line store is
// one RAM with one write and one registered read port per cycle.
// Reset clears the counters, the column window and the registers
// (out_width = out_height = 1); the line stores need no clearing pass.
// Write registers over the cfg channel only while the block is idle.
// When the receiver stalls, the finished result waits in the output register
// and the pixel behind it is held; src_ready drops only if that pixel also has
// a result to deliver.
module binomial_half_downscaler_unit #(
  parameter int unsigned MAX_SRC_WIDTH = bhd_pkg::DEF_MAX_SRC_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bhd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bhd_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           src_valid_i,
  output logic                           src_ready_o,
  input  logic [bhd_pkg::SRC_W-1:0]      src_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bhd_pkg::PIX_W-1:0]      out_pixel_o,
  output logic                           row_end_o,
  output logic                           frame_end_o
);
  import bhd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SRC_WIDTH);

  logic [CFG_W-1:0] out_width_q, out_height_q;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW:0]      idx_inc;
  logic [CNT_W-1:0] last_col, last_row;
  logic             col_end, row_last, emit_d;
  logic             src_acc, s1_adv, fwd_d;

  logic             s1_v_q, s1_emit_q, s1_row_end_q, s1_frame_end_q, fwd_q;
  logic [AW-1:0]    s1_addr_q;
  pixel_t           s1_pix_q, fwd_top_q, fwd_mid_q;
  pixel_t           up_rd, mid_rd, top_eff, mid_eff, filt_pix;
  col_t             win_q [2];
  col_t             cur_col;

  logic             out_v_q, out_row_end_q, out_frame_end_q;
  pixel_t           out_pix_q;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= CFG_W'(1);
      out_height_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        REG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1 moves on unless its result finds the output register occupied by a stalled result.
  assign s1_adv      = s1_v_q && (!s1_emit_q || !out_v_q || out_ready_i);
  assign src_ready_o = !s1_v_q || s1_adv;
  assign src_acc     = src_valid_i && src_ready_o;

  assign last_col = {out_width_q, 1'b0};
  assign last_row = {out_height_q, 1'b0};
  assign col_end  = col_q >= last_col;
  assign row_last = row_q >= last_row;
  assign emit_d   = (col_q >= CNT_W'(2)) && (row_q >= CNT_W'(2)) && !col_q[0] && !row_q[0];
  assign idx_inc  = {1'b0, idx_q} + (AW+1)'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (src_acc) begin
      if (col_end) begin
        col_d = '0;
        idx_d = '0;
        row_d = row_last ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
        idx_d = (idx_inc == (AW+1)'(MAX_SRC_WIDTH)) ? '0 : idx_inc[AW-1:0];
      end
    end
  end

  // Read and write of the same entry in one cycle: forward the written data.
  assign fwd_d   = s1_adv && (s1_addr_q == idx_q);
  assign top_eff = fwd_q ? fwd_top_q : up_rd;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rd;
  assign cur_col = '{top: top_eff, mid: mid_eff, bot: s1_pix_q};

  bhd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SRC_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_eff),
    .re_i    (src_acc),
    .raddr_i (idx_q),
    .rdata_o (up_rd)
  );

  bhd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SRC_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (src_acc),
    .raddr_i (idx_q),
    .rdata_o (mid_rd)
  );

  bhd_filter u_filter (
    .left_i   (win_q[0]),
    .center_i (win_q[1]),
    .right_i  (cur_col),
    .pixel_o  (filt_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      idx_q    <= '0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      win_q[0] <= '0;
      win_q[1] <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      idx_q <= idx_d;
      if (src_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q[0] <= win_q[1];
        win_q[1] <= cur_col;
      end
      if (s1_adv && s1_emit_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_acc) begin
      s1_pix_q       <= src_pixel_i[PIX_W-1:0];
      s1_emit_q      <= emit_d;
      s1_row_end_q   <= col_end;
      s1_frame_end_q <= col_end && row_last;
      s1_addr_q      <= idx_q;
      fwd_q          <= fwd_d;
      fwd_top_q      <= mid_eff;
      fwd_mid_q      <= s1_pix_q;
    end
    if (s1_adv && s1_emit_q) begin
      out_pix_q       <= filt_pix;
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_pixel_o = out_pix_q;
  assign row_end_o   = out_row_end_q;
  assign frame_end_o = out_frame_end_q;

endmodule

// ===== rtl/bhd_assert.sv =====
// Port-level checks of the binomial half downscaler, bound to its top level.
module bhd_assert (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [bhd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [bhd_pkg::CFG_W-1:0]      cfg_data_i,
  input logic                           src_valid_i,
  input logic                           src_ready_o,
  input logic [bhd_pkg::SRC_W-1:0]      src_pixel_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bhd_pkg::PIX_W-1:0]      out_pixel_o,
  input logic                           row_end_o,
  input logic                           frame_end_o
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_pixel_o) && $stable(row_end_o) && $stable(frame_end_o))
    else $error("stalled result changed or dropped");

  // The last pixel of a frame also closes its row.
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // With the output register empty nothing blocks the source side.
  a_src_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> src_ready_o)
    else $error("source stalled with empty output");

  // Register writes are never back-pressured.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind binomial_half_downscaler_unit bhd_assert u_bhd_assert (.*);
